// ----- sv/rct_pkg.sv -----
// Shared types and constants for the request correlation table.
// Used by rct_entry_ram and request_correlation_table; no dependencies.
`timescale 1ns / 1ps

package rct_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = IDX_W + 1;
    localparam int TIME_W  = 63;

    localparam logic [31:0] WINDOW_RESET = 32'd3500000;

    localparam logic [1:0] CMD_TRACK = 2'd0;
    localparam logic [1:0] CMD_TAKE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_INVALID   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [31:0]       generation;
        logic [31:0]       request_id;
        logic [31:0]       reply_tag;
        logic [TIME_W-1:0] now_us;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] found_tag;
    } rsp_t;

    typedef struct packed {
        logic [31:0]       generation;
        logic [31:0]       request_id;
        logic [31:0]       tag;
        logic [TIME_W-1:0] deadline;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

endpackage

// ----- sv/request_correlation_table.sv -----
// Top level of the request correlation table: control, occupancy bits,
// window register and output register. Depends on rct_pkg and rct_entry_ram.
//
//   channel   direction  signals                        content
//   s_        in         s_valid, s_ready, s_payload    req_t command item
//   m_        out        m_valid, m_ready, m_payload    rsp_t status and tag
//   cfg_      in         cfg_valid, cfg_ready, cfg_wdata timeout window, us
//
// A track or take with valid arguments sweeps the table: the entry RAM is read
// once per entry, one read per cycle, then the final state applies the result.
// Clear, invalid and unknown items go straight to the final state.
// Reset empties the table at once through per-entry occupancy flip-flops.
// A stalled output holds the finished item in the final state until taken.
`timescale 1ns / 1ps

module request_correlation_table
    import rct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_payload,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_wdata
);

    state_t              state_reg, state_next;
    logic [31:0]         window_reg;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    req_t                req_reg, req_next;
    logic [TIME_W-1:0]   deadline_reg, deadline_next;
    logic                swept_reg, swept_next;
    status_t             pre_status_reg, pre_status_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                rdv_reg, rdv_next;
    logic [IDX_W-1:0]    eval_idx_reg, eval_idx_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [31:0]         tag_reg, tag_next;
    logic                m_valid_reg, m_valid_next;
    rsp_t                m_payload_reg, m_payload_next;

    logic                rd_en;
    entry_t              rd_data;
    ram_wr_t             wr;
    logic [TIME_W:0]     sum;
    logic                expire;
    logic                live;
    logic                cand;
    logic                is_track;
    logic                args_ok;

    rct_entry_ram u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr      (wr)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign is_track = (req_reg.command == CMD_TRACK);
    assign sum      = {1'b0, s_payload.now_us} + {{(TIME_W - 31){1'b0}}, window_reg};

    // Expiry and match are judged on the entry read in the previous cycle.
    assign expire = rdv_reg && valid_reg[eval_idx_reg]
                    && (rd_data.deadline <= req_reg.now_us);
    assign live   = rdv_reg && valid_reg[eval_idx_reg]
                    && (rd_data.deadline > req_reg.now_us);
    assign cand   = is_track ? (rdv_reg && (!valid_reg[eval_idx_reg] || expire))
                             : (live && (rd_data.generation == req_reg.generation)
                                     && (rd_data.request_id == req_reg.request_id));

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        req_next        = req_reg;
        deadline_next   = deadline_reg;
        swept_next      = swept_reg;
        pre_status_next = pre_status_reg;
        rd_cnt_next     = rd_cnt_reg;
        rdv_next        = 1'b0;
        eval_idx_next   = eval_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        tag_next        = tag_reg;
        m_valid_next    = m_valid_reg;
        m_payload_next  = m_payload_reg;
        rd_en           = 1'b0;
        wr.en           = 1'b0;
        wr.addr         = hit_idx_reg;
        wr.data.generation = req_reg.generation;
        wr.data.request_id = req_reg.request_id;
        wr.data.tag        = req_reg.reply_tag;
        wr.data.deadline   = deadline_reg;
        args_ok         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_payload;
                    deadline_next = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
                    rd_cnt_next   = '0;
                    hit_next      = 1'b0;
                    tag_next      = '0;
                    priority if (s_payload.command == CMD_TRACK) begin
                        args_ok = (s_payload.generation != '0)
                                  && (s_payload.request_id != '0)
                                  && (s_payload.reply_tag != '0);
                    end else if (s_payload.command == CMD_TAKE) begin
                        args_ok = (s_payload.generation != '0)
                                  && (s_payload.request_id != '0);
                    end else begin
                        args_ok = 1'b0;
                    end
                    swept_next = args_ok;
                    if (s_payload.command == CMD_CLEAR) begin
                        valid_next      = '0;
                        pre_status_next = STAT_OK;
                    end else begin
                        pre_status_next = STAT_INVALID;
                    end
                    state_next = args_ok ? ST_SWEEP : ST_DONE;
                end
            end
            ST_SWEEP: begin
                if (rd_cnt_reg < CNT_W'(ENTRIES)) begin
                    rd_en         = 1'b1;
                    rdv_next      = 1'b1;
                    eval_idx_next = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                end
                if (expire) begin
                    valid_next[eval_idx_reg] = 1'b0;
                end
                if (cand && !hit_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = eval_idx_reg;
                    tag_next     = rd_data.tag;
                end
                if (rdv_reg && (eval_idx_reg == IDX_W'(ENTRIES - 1))) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_payload_next.found_tag = '0;
                    if (!swept_reg) begin
                        m_payload_next.status = pre_status_reg;
                    end else if (is_track) begin
                        m_payload_next.status = hit_reg ? STAT_OK : STAT_FULL;
                        if (hit_reg) begin
                            wr.en                   = 1'b1;
                            valid_next[hit_idx_reg] = 1'b1;
                        end
                    end else begin
                        m_payload_next.status = hit_reg ? STAT_OK : STAT_NOT_FOUND;
                        if (hit_reg) begin
                            m_payload_next.found_tag = tag_reg;
                            valid_next[hit_idx_reg]  = 1'b0;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            window_reg  <= WINDOW_RESET;
            m_valid_reg <= 1'b0;
            rdv_reg     <= 1'b0;
            rd_cnt_reg  <= '0;
            hit_reg     <= 1'b0;
            swept_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            rdv_reg     <= rdv_next;
            rd_cnt_reg  <= rd_cnt_next;
            hit_reg     <= hit_next;
            swept_reg   <= swept_next;
            if (cfg_valid && cfg_ready) begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        deadline_reg   <= deadline_next;
        pre_status_reg <= pre_status_next;
        eval_idx_reg   <= eval_idx_next;
        hit_idx_reg    <= hit_idx_next;
        tag_reg        <= tag_next;
        m_payload_reg  <= m_payload_next;
    end

    // A clear item empties every entry on the following cycle.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_payload.command == CMD_CLEAR)) |=> (valid_reg == '0))
        else $error("table not empty after clear");

    // Read data is only judged while the sweep is running.
    a_eval_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        rdv_reg |-> (state_reg == ST_SWEEP))
        else $error("entry evaluated outside sweep");

    // A new result appears only as the final state completes.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg && !m_ready)) |-> $past(state_reg == ST_DONE))
        else $error("result produced outside final state");

    // A stored track leaves its slot occupied.
    a_track_occupies: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |=> valid_reg[$past(hit_idx_reg)])
        else $error("tracked slot not marked occupied");

endmodule

// ----- sv/rct_entry_ram.sv -----
// Entry store of the request correlation table: one write port and one
// read port with registered read data. Depends on rct_pkg.
`timescale 1ns / 1ps

module rct_entry_ram
    import rct_pkg::*;
(
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data,
    input  ram_wr_t          wr
);

    entry_t mem_array [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_array[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for request_correlation_table: directed rows, then
// random track, take and clear items under several timeout windows.
// Depends on rct_pkg and the request_correlation_table RTL.
`timescale 1ns / 1ps

module testbench;
    import rct_pkg::*;

    localparam logic [1:0]        CMD_UNKNOWN      = 2'd3;
    localparam logic [TIME_W-1:0] TIME_LIMIT       = {TIME_W{1'b1}};
    localparam int                PHASES           = 6;
    localparam int                RANDOM_PER_PHASE = 258;
    localparam int                DIR_MAX          = 24;
    localparam int                WATCHDOG_CYCLES  = 2000;
    localparam int                SETTLE_CYCLES    = 4;
    localparam int                TAIL_CYCLES      = 25;

    typedef struct packed {
        req_t req;
        logic typed;
        rsp_t reply;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    req_t        s_payload = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    rsp_t        m_payload;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_wdata = '0;

    // Shadow copy of the table and the window register.
    logic [31:0]       tbl_gen      [ENTRIES];
    logic [31:0]       tbl_rid      [ENTRIES];
    logic [31:0]       tbl_tag      [ENTRIES];
    logic [TIME_W-1:0] tbl_deadline [ENTRIES];
    logic [31:0]       window_us = WINDOW_RESET;

    rsp_t        pending_replies [$];
    rsp_t        want_reply;
    logic [63:0] open_pairs [$];
    dir_row_t    dir_rows [DIR_MAX];
    int          dir_count     = 0;
    int          error_count   = 0;
    int          send_idle_pct = 7;
    int          recv_idle_pct = 50;
    int          stall_cycles  = 0;
    logic [TIME_W-1:0] cur_time = '0;

    request_correlation_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void free_entry(input int i);
        tbl_gen[i]      = '0;
        tbl_rid[i]      = '0;
        tbl_tag[i]      = '0;
        tbl_deadline[i] = '0;
    endfunction

    function automatic void expire_entries(input logic [TIME_W-1:0] now);
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            if (tbl_rid[i] != 0 && tbl_deadline[i] <= now) begin
                free_entry(i);
            end
        end
    endfunction

    function automatic rsp_t predict_reply(input req_t r);
        rsp_t              rsp;
        logic [63:0]       sum;
        logic [TIME_W-1:0] deadline;
        logic              done;
        int                i;
        rsp.status    = STAT_INVALID;
        rsp.found_tag = '0;
        done          = 1'b0;
        case (r.command)
            CMD_TRACK: begin
                if (r.generation != 0 && r.request_id != 0 && r.reply_tag != 0) begin
                    // The deadline saturates once the sum passes the time range.
                    sum      = {1'b0, r.now_us} + {32'd0, window_us};
                    deadline = sum[63] ? TIME_LIMIT : sum[TIME_W-1:0];
                    expire_entries(r.now_us);
                    rsp.status = STAT_FULL;
                    for (i = 0; i < ENTRIES; i++) begin
                        if (!done && tbl_rid[i] == 0) begin
                            tbl_gen[i]      = r.generation;
                            tbl_rid[i]      = r.request_id;
                            tbl_tag[i]      = r.reply_tag;
                            tbl_deadline[i] = deadline;
                            rsp.status      = STAT_OK;
                            done            = 1'b1;
                        end
                    end
                end
            end
            CMD_TAKE: begin
                if (r.generation != 0 && r.request_id != 0) begin
                    expire_entries(r.now_us);
                    rsp.status = STAT_NOT_FOUND;
                    for (i = 0; i < ENTRIES; i++) begin
                        if (!done && tbl_gen[i] == r.generation &&
                            tbl_rid[i] == r.request_id) begin
                            rsp.found_tag = tbl_tag[i];
                            rsp.status    = STAT_OK;
                            free_entry(i);
                            done          = 1'b1;
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                for (i = 0; i < ENTRIES; i++) begin
                    free_entry(i);
                end
                rsp.status = STAT_OK;
            end
            default: begin
                rsp.status = STAT_INVALID;
            end
        endcase
        return rsp;
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [31:0] gen,
                           input logic [31:0] rid, input logic [31:0] tag,
                           input logic [TIME_W-1:0] now, input logic typed,
                           input status_t st, input logic [31:0] ftag);
        dir_row_t row;
        row.req.command     = cmd;
        row.req.generation  = gen;
        row.req.request_id  = rid;
        row.req.reply_tag   = tag;
        row.req.now_us      = now;
        row.typed           = typed;
        row.reply.status    = st;
        row.reply.found_tag = ftag;
        dir_rows[dir_count] = row;
        dir_count++;
    endtask

    function automatic logic [31:0] pick_gen();
        return ($urandom_range(3) == 0) ? $urandom : $urandom_range(3, 1);
    endfunction

    function automatic logic [31:0] pick_rid();
        return ($urandom_range(3) == 0) ? $urandom : $urandom_range(24, 1);
    endfunction

    // Mostly well-formed traffic: tracks, takes of pairs that were tracked,
    // rare clears, and some noise with zero fields or the unknown command.
    function automatic req_t next_random_req();
        req_t        r;
        int unsigned step_max;
        int unsigned roll;
        int          idx;
        logic [63:0] wide;
        logic [63:0] pair;
        step_max = (window_us >> 2) + 2;
        roll     = $urandom_range(99);
        if (roll < 85) begin
            cur_time = cur_time + $urandom_range(step_max);
            r.now_us = cur_time;
        end else if (roll < 93) begin
            r.now_us = cur_time - $urandom_range(step_max);
        end else begin
            wide     = {$urandom, $urandom};
            cur_time = wide[TIME_W-1:0];
            r.now_us = cur_time;
        end
        r.generation = pick_gen();
        r.request_id = pick_rid();
        r.reply_tag  = $urandom;
        roll         = $urandom_range(99);
        if (roll < 50) begin
            r.command = CMD_TRACK;
            open_pairs.push_back({r.generation, r.request_id});
            if (open_pairs.size() > 48) begin
                pair = open_pairs.pop_front();
            end
        end else if (roll < 90) begin
            r.command = CMD_TAKE;
            if (open_pairs.size() > 0 && $urandom_range(9) < 7) begin
                idx          = $urandom_range(open_pairs.size() - 1);
                pair         = open_pairs[idx];
                open_pairs.delete(idx);
                r.generation = pair[63:32];
                r.request_id = pair[31:0];
            end
        end else if (roll < 92) begin
            r.command = CMD_CLEAR;
        end else if (roll < 95) begin
            r.command = CMD_UNKNOWN;
        end else begin
            r.command = $urandom_range(1) ? CMD_TRACK : CMD_TAKE;
            case ($urandom_range(2))
                0:       r.generation = '0;
                1:       r.request_id = '0;
                default: r.reply_tag  = '0;
            endcase
        end
        return r;
    endfunction

    task automatic send_cmd(input req_t r, input logic use_typed, input rsp_t typed_reply);
        rsp_t reply;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
        reply = predict_reply(r);
        if (use_typed) begin
            reply = typed_reply;
        end
        pending_replies.push_back(reply);
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        window_us = value;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply: status %0d found_tag %0h",
                       m_payload.status, m_payload.found_tag);
                error_count++;
            end else begin
                want_reply = pending_replies.pop_front();
                if (m_payload.status !== want_reply.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want_reply.status, m_payload.status);
                    error_count++;
                end
                if (m_payload.found_tag !== want_reply.found_tag) begin
                    $error("found_tag mismatch: expected %0h, actual %0h",
                           want_reply.found_tag, m_payload.found_tag);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int          k;
        int          phase;
        int          n;
        logic [31:0] phase_window;
        for (k = 0; k < ENTRIES; k++) begin
            free_entry(k);
        end

        // Error codes, extremes, expiry at the deadline, saturation and clear.
        add_row(CMD_TAKE,    32'd1, 32'd1, 32'd0, '0, 1'b1, STAT_NOT_FOUND, 32'd0);
        add_row(CMD_TRACK,   32'd0, 32'd5, 32'd7, '0, 1'b1, STAT_INVALID, 32'd0);
        add_row(CMD_TRACK,   32'd5, 32'd0, 32'd7, '0, 1'b1, STAT_INVALID, 32'd0);
        add_row(CMD_TRACK,   32'd5, 32'd5, 32'd0, '0, 1'b1, STAT_INVALID, 32'd0);
        add_row(CMD_TAKE,    32'd0, 32'd5, 32'd0, '0, 1'b1, STAT_INVALID, 32'd0);
        add_row(CMD_TAKE,    32'd5, 32'd0, 32'd0, '0, 1'b1, STAT_INVALID, 32'd0);
        add_row(CMD_UNKNOWN, '1, '1, '1, TIME_LIMIT, 1'b1, STAT_INVALID, 32'd0);
        add_row(CMD_TRACK,   '1, '1, '1, '0, 1'b1, STAT_OK, 32'd0);
        add_row(CMD_TRACK,   32'd1, 32'd2, 32'd3, 63'd100, 1'b1, STAT_OK, 32'd0);
        add_row(CMD_TAKE,    '1, '1, '0, WINDOW_RESET - 1, 1'b1, STAT_OK, '1);
        add_row(CMD_TAKE,    32'd1, 32'd2, 32'd0, WINDOW_RESET + 100, 1'b0, STAT_OK, 32'd0);
        add_row(CMD_TRACK,   32'd2, 32'd2, 32'd9, TIME_LIMIT, 1'b0, STAT_OK, 32'd0);
        add_row(CMD_TRACK,   32'd2, 32'd3, 32'd10, TIME_LIMIT - 5, 1'b0, STAT_OK, 32'd0);
        add_row(CMD_TAKE,    32'd2, 32'd3, 32'd0, 63'd10, 1'b0, STAT_OK, 32'd0);
        add_row(CMD_TAKE,    32'd2, 32'd2, 32'd0, TIME_LIMIT, 1'b0, STAT_OK, 32'd0);
        add_row(CMD_TRACK,   32'd7, 32'd7, 32'd7, 63'd50, 1'b0, STAT_OK, 32'd0);
        add_row(CMD_CLEAR,   '1, '1, '1, TIME_LIMIT, 1'b1, STAT_OK, 32'd0);
        add_row(CMD_TAKE,    32'd7, 32'd7, 32'd0, 63'd50, 1'b1, STAT_NOT_FOUND, 32'd0);
        add_row(CMD_TRACK,   32'd8, 32'd9, 32'd1, 63'd0, 1'b0, STAT_OK, 32'd0);
        add_row(CMD_TAKE,    32'd9, 32'd9, 32'd0, 63'd0, 1'b0, STAT_OK, 32'd0);
        add_row(CMD_TAKE,    32'd8, 32'd9, 32'd0, 63'd0, 1'b0, STAT_OK, 32'd0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < dir_count; k++) begin
            send_cmd(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].reply);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       phase_window = 32'd1;
                1:       phase_window = 32'd0;
                2:       phase_window = 32'hFFFF_FFFF;
                3:       phase_window = 32'd1000;
                4:       phase_window = $urandom_range(5000000, 1);
                default: phase_window = WINDOW_RESET;
            endcase
            if (phase == 2) begin
                send_idle_pct = 50;
                recv_idle_pct = 7;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain_replies();
            write_window(phase_window);
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Halfway through, hold off until the table has answered everything.
                if (n == RANDOM_PER_PHASE / 2) begin
                    drain_replies();
                end
                send_cmd(next_random_req(), 1'b0, '0);
            end
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_replies.size() != 0) begin
            $error("%0d replies never arrived", pending_replies.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
